// File: rtl/evci_pkg.sv
// Shared types and codes for the event coalescing invalidator.
package evci_pkg;

    localparam int ID_W        = 3;
    localparam int CNT_W       = 4;
    localparam int MASK_W      = 64;
    localparam int MASK_STRIDE = 8;
    localparam int CFG_IDX_W   = 2;

    localparam logic [1:0] FUNC_EVENT    = 2'd0;
    localparam logic [1:0] FUNC_DISPATCH = 2'd1;
    localparam logic [1:0] FUNC_SET_VIS  = 2'd2;
    localparam logic [1:0] FUNC_QUERY    = 2'd3;

    localparam logic [1:0] KIND_INVALIDATE = 2'd0;
    localparam logic [1:0] KIND_DONE       = 2'd1;
    localparam logic [1:0] KIND_QUERY      = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASKS = 2'd1;

    typedef struct packed {
        logic             dispatch;
        logic             set_vis;
        logic             vis;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] count;
        logic             cfg_count;
        logic [CNT_W-1:0] new_count;
    } t_cell_cmd;

    typedef struct packed {
        logic scan_hit;
        logic vis_hit;
        logic q_dirty;
    } t_cell_stat;

endpackage

// File: rtl/evci_cell.sv
// One target cell: dirty and visible marks, scan token passed to the next cell.
module evci_cell #(
    parameter int IDX        = 0,
    parameter int EVENT_BITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  evci_pkg::t_cell_cmd   i_cmd,
    input  logic [EVENT_BITS-1:0] i_mask,
    input  logic [EVENT_BITS-1:0] i_pending,
    input  logic                  i_tok,
    output logic                  o_tok,
    output evci_pkg::t_cell_stat  o_stat
);

    localparam logic [evci_pkg::CNT_W-1:0] MY_CNT = evci_pkg::CNT_W'(IDX);
    localparam logic [evci_pkg::ID_W-1:0]  MY_ID  = evci_pkg::ID_W'(IDX);

    logic r_dirty, n_dirty;
    logic r_vis, n_vis;
    logic r_tok;
    logic registered;
    logic sel;
    logic scan_hit;
    logic vis_hit;
    logic fresh;

    assign registered = MY_CNT < i_cmd.count;
    assign sel        = registered && (i_cmd.id == MY_ID);
    assign scan_hit   = r_tok && registered && r_dirty && r_vis;
    assign vis_hit    = i_cmd.set_vis && sel && i_cmd.vis && !r_vis && r_dirty;
    assign fresh      = i_cmd.cfg_count && (MY_CNT >= i_cmd.count)
                        && (MY_CNT < i_cmd.new_count);

    always_comb begin
        n_dirty = r_dirty;
        n_vis   = r_vis;
        if (fresh) begin
            n_dirty = 1'b0;
            n_vis   = 1'b1;
        end
        if (i_cmd.dispatch && registered && (|(i_mask & i_pending))) begin
            n_dirty = 1'b1;
        end
        if (i_cmd.set_vis && sel) begin
            n_vis = i_cmd.vis;
        end
        if (vis_hit || scan_hit) begin
            n_dirty = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dirty <= 1'b0;
            r_vis   <= 1'b1;
            r_tok   <= 1'b0;
        end else begin
            r_dirty <= n_dirty;
            r_vis   <= n_vis;
            r_tok   <= i_tok;
        end
    end

    assign o_tok           = r_tok;
    assign o_stat.scan_hit = scan_hit;
    assign o_stat.vis_hit  = vis_hit;
    assign o_stat.q_dirty  = sel && r_dirty;

endmodule

// File: rtl/event_coalescing_invalidator_core.sv
// Event coalescing invalidator, top level.
// Set-visibility and query results are registered and appear the cycle after start;
// an event gives none. Dispatch: a token walks the target cells, one per cycle, and busy
// stays high until the token has left the last cell; busy falls as the done result appears.
// Results cannot be stalled. Synchronous active-low reset: all targets visible and clean,
// no pending events, target count and masks zero.
module event_coalescing_invalidator_core #(
    parameter int MAX_TARGETS = 8,
    parameter int EVENT_BITS  = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [1:0]                        i_func,
    input  logic [2:0]                        i_event_code,
    input  logic [evci_pkg::ID_W-1:0]         i_target_id,
    input  logic                              i_visible_flag,
    output logic                              o_strobe,
    output logic [1:0]                        o_kind,
    output logic [evci_pkg::ID_W-1:0]         o_target_out,
    output logic                              o_dirty_answer,
    output logic [evci_pkg::CNT_W-1:0]        o_invalidated_count,
    output logic                              o_last,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [evci_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [evci_pkg::MASK_W-1:0]       i_cfg_data
);

    localparam logic [evci_pkg::CNT_W-1:0] MAX_CNT = evci_pkg::CNT_W'(MAX_TARGETS);
    localparam logic [3:0]                 EV_LIM  = 4'(EVENT_BITS);

    logic                          r_busy;
    logic                          r_fin;
    logic [EVENT_BITS-1:0]         r_pending, n_pending;
    logic [evci_pkg::CNT_W-1:0]    r_count;
    logic [evci_pkg::MASK_W-1:0]   r_masks;
    logic [evci_pkg::CNT_W-1:0]    r_inv_cnt;

    logic                          r_strobe, n_strobe;
    logic [1:0]                    r_kind, n_kind;
    logic [evci_pkg::ID_W-1:0]     r_tgt, n_tgt;
    logic                          r_dirty_ans, n_dirty_ans;
    logic [evci_pkg::CNT_W-1:0]    r_cnt_out, n_cnt_out;
    logic                          r_last, n_last;

    logic                          accept;
    logic                          disp_acc;
    logic                          cfg_wr;
    logic [evci_pkg::CNT_W-1:0]    sat_count;
    evci_pkg::t_cell_cmd           cmd;
    evci_pkg::t_cell_stat          stat [MAX_TARGETS];
    logic [MAX_TARGETS:0]          tok;
    logic [MAX_TARGETS-1:0]        scan_hits;
    logic [MAX_TARGETS-1:0]        vis_hits;
    logic [MAX_TARGETS-1:0]        q_hits;
    logic [evci_pkg::ID_W-1:0]     hit_id;

    assign accept   = start && !r_busy;
    assign disp_acc = accept && (i_func == evci_pkg::FUNC_DISPATCH);
    assign cfg_wr   = i_cfg_valid;
    assign sat_count = (i_cfg_data[evci_pkg::CNT_W-1:0] > MAX_CNT)
                       ? MAX_CNT : i_cfg_data[evci_pkg::CNT_W-1:0];

    always_comb begin
        cmd.dispatch  = disp_acc;
        cmd.set_vis   = accept && (i_func == evci_pkg::FUNC_SET_VIS);
        cmd.vis       = i_visible_flag;
        cmd.id        = i_target_id;
        cmd.count     = r_count;
        cmd.cfg_count = cfg_wr && (i_cfg_index == evci_pkg::CFG_COUNT);
        cmd.new_count = sat_count;
    end

    assign tok[0] = disp_acc;

    for (genvar g = 0; g < MAX_TARGETS; g++) begin : g_cell
        evci_cell #(
            .IDX        (g),
            .EVENT_BITS (EVENT_BITS)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (cmd),
            .i_mask    (r_masks[g*evci_pkg::MASK_STRIDE +: EVENT_BITS]),
            .i_pending (r_pending),
            .i_tok     (tok[g]),
            .o_tok     (tok[g+1]),
            .o_stat    (stat[g])
        );
        assign scan_hits[g] = stat[g].scan_hit;
        assign vis_hits[g]  = stat[g].vis_hit;
        assign q_hits[g]    = stat[g].q_dirty;
    end

    always_comb begin
        hit_id = '0;
        for (int i = 0; i < MAX_TARGETS; i++) begin
            if (scan_hits[i]) begin
                hit_id = hit_id | evci_pkg::ID_W'(i);
            end
        end
    end

    always_comb begin
        n_pending = r_pending;
        if (accept && (i_func == evci_pkg::FUNC_EVENT) && ({1'b0, i_event_code} < EV_LIM)) begin
            n_pending = r_pending | (EVENT_BITS'(1) << i_event_code);
        end
        if (disp_acc) begin
            n_pending = '0;
        end
    end

    always_comb begin
        n_strobe    = 1'b0;
        n_kind      = evci_pkg::KIND_INVALIDATE;
        n_tgt       = '0;
        n_dirty_ans = 1'b0;
        n_cnt_out   = '0;
        n_last      = 1'b0;
        if (r_fin) begin
            n_strobe  = 1'b1;
            n_kind    = evci_pkg::KIND_DONE;
            n_cnt_out = r_inv_cnt;
            n_last    = 1'b1;
        end else if (|scan_hits) begin
            n_strobe = 1'b1;
            n_tgt    = hit_id;
        end else if (accept) begin
            case (i_func)
                evci_pkg::FUNC_SET_VIS: begin
                    n_strobe = |vis_hits;
                    n_tgt    = i_target_id;
                    n_last   = 1'b1;
                end
                evci_pkg::FUNC_QUERY: begin
                    n_strobe    = 1'b1;
                    n_kind      = evci_pkg::KIND_QUERY;
                    n_tgt       = i_target_id;
                    n_dirty_ans = |q_hits;
                    n_last      = 1'b1;
                end
                default: begin
                    n_strobe = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_fin     <= 1'b0;
            r_pending <= '0;
            r_count   <= '0;
            r_masks   <= '0;
            r_strobe  <= 1'b0;
        end else begin
            r_pending <= n_pending;
            r_strobe  <= n_strobe;
            r_fin     <= tok[MAX_TARGETS];
            if (disp_acc) begin
                r_busy <= 1'b1;
            end else if (r_fin) begin
                r_busy <= 1'b0;
            end
            if (cmd.cfg_count) begin
                r_count <= sat_count;
            end
            if (cfg_wr && (i_cfg_index == evci_pkg::CFG_MASKS)) begin
                r_masks <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (disp_acc) begin
            r_inv_cnt <= '0;
        end else if (|scan_hits) begin
            r_inv_cnt <= r_inv_cnt + 1'b1;
        end
        r_kind      <= n_kind;
        r_tgt       <= n_tgt;
        r_dirty_ans <= n_dirty_ans;
        r_cnt_out   <= n_cnt_out;
        r_last      <= n_last;
    end

    assign busy                = r_busy;
    assign o_cfg_ready         = 1'b1;
    assign o_strobe            = r_strobe;
    assign o_kind              = r_kind;
    assign o_target_out        = r_tgt;
    assign o_dirty_answer      = r_dirty_ans;
    assign o_invalidated_count = r_cnt_out;
    assign o_last              = r_last;

`ifndef ASSERT_OFF
    a_tok_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(tok[MAX_TARGETS:1]))
        else $error("more than one scan token in flight");

    a_no_scan_when_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !(|scan_hits))
        else $error("scan hit outside a dispatch");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |=> o_strobe && (o_kind == evci_pkg::KIND_DONE) && o_last && !busy)
        else $error("dispatch did not close with a done result");

    a_busy_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe && (o_kind == evci_pkg::KIND_DONE))
        else $error("busy dropped without a done result");
`endif

endmodule

// File: dv/tb_event_coalescing_invalidator_core.sv
// Self-checking testbench for the event coalescing invalidator core.
`timescale 1ns / 1ps

module tb_event_coalescing_invalidator_core;

    localparam int MAX_TARGETS  = 8;
    localparam int EVENT_BITS   = 8;
    localparam int SETTLE_CYC   = MAX_TARGETS + 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 30;

    localparam logic [evci_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [evci_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic [1:0]                 kind;
        logic [evci_pkg::ID_W-1:0]  target;
        logic                       dirty;
        logic [evci_pkg::CNT_W-1:0] count;
        logic                       last;
    } t_notice;

    typedef struct {
        bit                             is_cfg;
        logic [evci_pkg::CFG_IDX_W-1:0] cfg_idx;
        logic [evci_pkg::MASK_W-1:0]    cfg_data;
        logic [1:0]                     func;
        logic [2:0]                     ecode;
        logic [evci_pkg::ID_W-1:0]      id;
        logic                           vis;
        bit                             typed;
        t_notice                        want;
    } t_step;

    logic                            i_clk          = 1'b0;
    logic                            i_rst_n        = 1'b0;
    logic                            start          = 1'b0;
    logic                            busy;
    logic [1:0]                      i_func         = evci_pkg::FUNC_EVENT;
    logic [2:0]                      i_event_code   = 3'd0;
    logic [evci_pkg::ID_W-1:0]       i_target_id    = '0;
    logic                            i_visible_flag = 1'b0;
    logic                            o_strobe;
    logic [1:0]                      o_kind;
    logic [evci_pkg::ID_W-1:0]       o_target_out;
    logic                            o_dirty_answer;
    logic [evci_pkg::CNT_W-1:0]      o_invalidated_count;
    logic                            o_last;
    logic                            i_cfg_valid    = 1'b0;
    logic                            o_cfg_ready;
    logic [evci_pkg::CFG_IDX_W-1:0]  i_cfg_index    = evci_pkg::CFG_COUNT;
    logic [evci_pkg::MASK_W-1:0]     i_cfg_data     = '0;

    event_coalescing_invalidator_core #(
        .MAX_TARGETS(MAX_TARGETS),
        .EVENT_BITS (EVENT_BITS)
    ) DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_func             (i_func),
        .i_event_code       (i_event_code),
        .i_target_id        (i_target_id),
        .i_visible_flag     (i_visible_flag),
        .o_strobe           (o_strobe),
        .o_kind             (o_kind),
        .o_target_out       (o_target_out),
        .o_dirty_answer     (o_dirty_answer),
        .o_invalidated_count(o_invalidated_count),
        .o_last             (o_last),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the target table
    logic [7:0]                  pend_ev;
    logic [7:0]                  dirty_bits;
    logic [7:0]                  shown_bits;
    int                          reg_count;
    logic [evci_pkg::MASK_W-1:0] reg_masks;

    t_notice outgoing[$];
    t_notice batch[$];
    int      error_count = 0;
    int      cycles      = 0;
    bit      allow_gaps  = 1'b1;
    t_step   directed_steps[$];

    function automatic void apply_register(logic [evci_pkg::CFG_IDX_W-1:0] idx,
                                           logic [evci_pkg::MASK_W-1:0] data);
        int n;
        if (idx == evci_pkg::CFG_COUNT) begin
            n = int'(data[3:0]);
            if (n > MAX_TARGETS) n = MAX_TARGETS;
            for (int i = reg_count; i < n; i++) begin
                shown_bits[i] = 1'b1;
                dirty_bits[i] = 1'b0;
            end
            reg_count = n;
        end else if (idx == evci_pkg::CFG_MASKS) begin
            reg_masks = data;
        end
    endfunction

    function automatic void predict_command(logic [1:0] f, logic [2:0] ec,
                                            logic [evci_pkg::ID_W-1:0] id, logic v);
        int  n;
        bit  entering;
        batch = {};
        case (f)
            evci_pkg::FUNC_EVENT: begin
                if (int'(ec) < EVENT_BITS) pend_ev = pend_ev | (8'd1 << ec);
            end
            evci_pkg::FUNC_DISPATCH: begin
                n = 0;
                for (int i = 0; i < reg_count; i++)
                    if ((reg_masks[i*8 +: 8] & pend_ev) != 8'd0) dirty_bits[i] = 1'b1;
                pend_ev = 8'd0;
                for (int i = 0; i < reg_count; i++) begin
                    if (dirty_bits[i] && shown_bits[i]) begin
                        dirty_bits[i] = 1'b0;
                        batch.push_back('{evci_pkg::KIND_INVALIDATE, evci_pkg::ID_W'(i),
                                          1'b0, '0, 1'b0});
                        n++;
                    end
                end
                batch.push_back('{evci_pkg::KIND_DONE, '0, 1'b0, evci_pkg::CNT_W'(n), 1'b1});
            end
            evci_pkg::FUNC_SET_VIS: begin
                if (int'(id) < reg_count) begin
                    entering = v && !shown_bits[id];
                    shown_bits[id] = v;
                    if (entering && dirty_bits[id]) begin
                        dirty_bits[id] = 1'b0;
                        batch.push_back('{evci_pkg::KIND_INVALIDATE, id, 1'b0, '0, 1'b1});
                    end
                end
            end
            default: begin
                batch.push_back('{evci_pkg::KIND_QUERY, id,
                                  (int'(id) < reg_count) && dirty_bits[id], '0, 1'b1});
            end
        endcase
    endfunction

    function automatic t_step cmd_row(logic [1:0] f, logic [2:0] ec,
                                      logic [evci_pkg::ID_W-1:0] id, logic v);
        t_step s;
        s = '{default: '0};
        s.func  = f;
        s.ecode = ec;
        s.id    = id;
        s.vis   = v;
        return s;
    endfunction

    function automatic t_step cfg_row(logic [evci_pkg::CFG_IDX_W-1:0] idx,
                                      logic [evci_pkg::MASK_W-1:0] data);
        t_step s;
        s = '{default: '0};
        s.is_cfg   = 1'b1;
        s.cfg_idx  = idx;
        s.cfg_data = data;
        return s;
    endfunction

    function automatic t_step typed_row(logic [1:0] f, logic [evci_pkg::ID_W-1:0] id,
                                        logic [1:0] k, logic [evci_pkg::CNT_W-1:0] cnt);
        t_step s;
        s = cmd_row(f, 3'd0, id, 1'b0);
        s.typed = 1'b1;
        s.want  = '{k, id, 1'b0, cnt, 1'b1};
        return s;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] %s", $time, msg);
        error_count++;
    endtask

    task automatic drive_cmd(t_step s);
        start          <= 1'b1;
        i_func         <= s.func;
        i_event_code   <= s.ecode;
        i_target_id    <= s.id;
        i_visible_flag <= s.vis;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_command(s.func, s.ecode, s.id, s.vis);
        if (s.typed) outgoing.push_back(s.want);
        else foreach (batch[j]) outgoing.push_back(batch[j]);
        if (allow_gaps && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (outgoing.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_register(logic [evci_pkg::CFG_IDX_W-1:0] idx,
                                  logic [evci_pkg::MASK_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_register(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic run_step(t_step s);
        if (s.is_cfg) begin
            settle();
            write_register(s.cfg_idx, s.cfg_data);
        end else begin
            drive_cmd(s);
        end
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_notice got;
        t_notice want;
        if (i_rst_n && o_strobe) begin
            got = '{o_kind, o_target_out, o_dirty_answer, o_invalidated_count, o_last};
            if (outgoing.size() == 0) begin
                report_mismatch($sformatf(
                    "unexpected result kind=%0d tgt=%0d dirty=%0d cnt=%0d last=%0d",
                    got.kind, got.target, got.dirty, got.count, got.last));
            end else begin
                want = outgoing.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "result got %0d/%0d/%0d/%0d/%0d exp %0d/%0d/%0d/%0d/%0d",
                        got.kind, got.target, got.dirty, got.count, got.last,
                        want.kind, want.target, want.dirty, want.count, want.last));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("event_coalescing_invalidator_core: mismatch");
            $finish;
        end
    end

    initial begin
        t_step                       s;
        logic [evci_pkg::MASK_W-1:0] m;
        pend_ev    = 8'd0;
        dirty_bits = 8'd0;
        shown_bits = 8'hFF;
        reg_count  = 0;
        reg_masks  = '0;

        directed_steps.push_back(typed_row(evci_pkg::FUNC_QUERY, 3'd0,
                                           evci_pkg::KIND_QUERY, 4'd0));
        directed_steps.push_back(typed_row(evci_pkg::FUNC_DISPATCH, 3'd0,
                                           evci_pkg::KIND_DONE, 4'd0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_SET_VIS, 3'd0, 3'd3, 1'b0));
        directed_steps.push_back(cfg_row(evci_pkg::CFG_COUNT, 64'd15));
        directed_steps.push_back(cfg_row(evci_pkg::CFG_MASKS, {evci_pkg::MASK_W{1'b1}}));
        directed_steps.push_back(cfg_row(CFG_SPARE_A, {evci_pkg::MASK_W{1'b1}}));
        directed_steps.push_back(cfg_row(CFG_SPARE_B, 64'h0123_4567_89AB_CDEF));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_EVENT, 3'd7, 3'd0, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_EVENT, 3'd0, 3'd7, 1'b1));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_DISPATCH, 3'd0, 3'd0, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_QUERY, 3'd0, 3'd7, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_SET_VIS, 3'd0, 3'd2, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_EVENT, 3'd3, 3'd0, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_DISPATCH, 3'd0, 3'd0, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_QUERY, 3'd0, 3'd2, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_SET_VIS, 3'd0, 3'd2, 1'b1));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_SET_VIS, 3'd0, 3'd2, 1'b1));
        directed_steps.push_back(cfg_row(evci_pkg::CFG_MASKS, 64'd0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_EVENT, 3'd5, 3'd0, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_DISPATCH, 3'd0, 3'd0, 1'b0));
        directed_steps.push_back(cfg_row(evci_pkg::CFG_MASKS, 64'h8040_2010_0804_0201));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_SET_VIS, 3'd0, 3'd5, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_EVENT, 3'd5, 3'd0, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_DISPATCH, 3'd0, 3'd0, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_QUERY, 3'd0, 3'd5, 1'b0));
        directed_steps.push_back(cfg_row(evci_pkg::CFG_COUNT, 64'd3));
        directed_steps.push_back(cfg_row(evci_pkg::CFG_COUNT, 64'd8));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_QUERY, 3'd0, 3'd5, 1'b0));
        directed_steps.push_back(cmd_row(evci_pkg::FUNC_SET_VIS, 3'd0, 3'd5, 1'b1));
        directed_steps.push_back(cfg_row(evci_pkg::CFG_COUNT, 64'd0));
        directed_steps.push_back(typed_row(evci_pkg::FUNC_QUERY, 3'd7,
                                           evci_pkg::KIND_QUERY, 4'd0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[k]) run_step(directed_steps[k]);

        for (int p = 0; p < PHASES; p++) begin
            allow_gaps = (p != PHASES - 1);
            if ($urandom_range(0, 2) == 0)
                run_step(cfg_row(evci_pkg::CFG_COUNT,
                                 evci_pkg::MASK_W'($urandom_range(0, 4))));
            case ($urandom_range(0, 4))
                0:       run_step(cfg_row(evci_pkg::CFG_COUNT,
                                          evci_pkg::MASK_W'(MAX_TARGETS)));
                1:       run_step(cfg_row(evci_pkg::CFG_COUNT,
                                          evci_pkg::MASK_W'($urandom_range(9, 15))));
                default: run_step(cfg_row(evci_pkg::CFG_COUNT,
                                          evci_pkg::MASK_W'($urandom_range(1, 8))));
            endcase
            case ($urandom_range(0, 2))
                0:       m = {$urandom, $urandom} & {$urandom, $urandom};
                1:       m = {$urandom, $urandom};
                default: m = {evci_pkg::MASK_W{1'b1}};
            endcase
            run_step(cfg_row(evci_pkg::CFG_MASKS, m));
            if ($urandom_range(0, 2) == 0)
                run_step(cfg_row($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                                 {$urandom, $urandom}));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: s = cmd_row(evci_pkg::FUNC_EVENT, 3'($urandom),
                                            3'($urandom), 1'($urandom));
                    4, 5:       s = cmd_row(evci_pkg::FUNC_DISPATCH, 3'($urandom),
                                            3'($urandom), 1'($urandom));
                    6, 7:       s = cmd_row(evci_pkg::FUNC_SET_VIS, 3'($urandom),
                                            3'($urandom), 1'($urandom));
                    default:    s = cmd_row(evci_pkg::FUNC_QUERY, 3'($urandom),
                                            3'($urandom), 1'($urandom));
                endcase
                run_step(s);
            end
            settle();
        end

        if (error_count == 0 && outgoing.size() == 0) begin
            $display("event_coalescing_invalidator_core: match");
        end else begin
            $display("event_coalescing_invalidator_core: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/evci_pkg.sv
rtl/evci_cell.sv
rtl/event_coalescing_invalidator_core.sv
dv/tb_event_coalescing_invalidator_core.sv
